// ===== rtl/lio_pkg.sv =====
`timescale 1ns / 1ps
package lio_pkg;
	localparam int MAX_SIDE_DEFAULT = 16;
	localparam int SIDE_W = 5;
	localparam int AREA_W = 9;
	localparam int SIDE_RESET = 16;
	localparam int AREA_MAX = 511;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_INIT,
		ST_CELL_RD,
		ST_CELL_CHK,
		ST_NB_SEL,
		ST_NB_CHK,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_CMP_RD,
		ST_CMP_WR,
		ST_UNI_RA,
		ST_UNI_RB,
		ST_UNI_WR,
		ST_SUM_RD,
		ST_SUM_ADD,
		ST_ADVANCE,
		ST_DONE
	} state_t;
endpackage

// ===== rtl/largest_island_one_flip_core.sv =====
`timescale 1ns / 1ps
// Loads a square binary image (side written via cfg_wdata, clamped to 1..MAX_SIDE) one cell per
// transfer in row-major order, then runs a union-find pass that merges land cells with their
// left and upper neighbors, followed by a pass over water cells that sums the distinct
// neighboring sets, and emits one result per image. After the last cell the input is not ready
// until both passes finish and the result is taken into the output register. The run time is
// set by the single-port memories with registered reads: a write per cell to set up the sets,
// then in each pass a read and a check of every cell, and for every visited cell a look at each
// neighbor slot, a read of each neighbor inside the image and a root walk with path compression
// for each land neighbor, then a union when the roots differ in the first pass and a sum over
// the distinct sets in the second. A finished result waits in the output register while the
// next image loads; the passes of that image stall only if they finish before it is taken.
module largest_island_one_flip_core #(
	parameter int MAX_SIDE = lio_pkg::MAX_SIDE_DEFAULT
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [lio_pkg::SIDE_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cell_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [lio_pkg::AREA_W-1:0] largest_island
);
	localparam int CAP = MAX_SIDE * MAX_SIDE;
	localparam int IW = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CW = $clog2(CAP + 1);
	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int AW = lio_pkg::AREA_W;
	localparam int GW = lio_pkg::SIDE_W;

	logic          cell_mem   [CAP];
	logic [IW-1:0] parent_mem [CAP];
	logic [CW-1:0] size_mem   [CAP];

	lio_pkg::state_t state_q, state_d;
	logic [GW-1:0] side_reg_q;
	logic [CW-1:0] loaded_q;
	logic [IW-1:0] pos_q;
	logic [SW-1:0] r_q, c_q;
	logic [2:0] k_q;
	logic pass2_q;
	logic fsel_q;
	logic [IW-1:0] x_q, root_q, cur_q, pa_q, pb_q;
	logic [CW-1:0] steps_q;
	logic [IW-1:0] roots_q [4];
	logic [2:0] cnt_q, j_q;
	logic [CW-1:0] sa_q, area_q, best_q;
	logic [AW-1:0] res_q;
	logic outv_q;
	logic rd_cell_q;
	logic [IW-1:0] rd_par_q;
	logic [CW-1:0] rd_size_q;

	logic [SW-1:0] side;
	logic [CW-1:0] total;
	always_comb begin
		if (side_reg_q == '0) side = SW'(1);
		else if (32'(side_reg_q) > MAX_SIDE) side = SW'(MAX_SIDE);
		else side = SW'(side_reg_q);
		total = CW'(32'(side) * 32'(side));
	end

	logic xfer_in;
	logic last_cell;
	logic init_end;
	logic res_load;
	assign in_ready = (state_q == lio_pkg::ST_LOAD) && !cfg_we;
	assign xfer_in = in_valid && in_ready;
	assign last_cell = (32'(loaded_q) + 32'd1) >= 32'(total);
	assign init_end = (32'(pos_q) + 32'd1) >= 32'(total);
	assign res_load = (state_q == lio_pkg::ST_DONE) && (!outv_q || out_ready);
	assign out_valid = outv_q;
	assign largest_island = res_q;

	// Neighbor slots follow the scan order: 0 left, 1 up, 2 right, 3 down.
	logic nb_ok;
	logic [IW-1:0] nb_addr;
	logic [IW-1:0] me_addr;
	always_comb begin
		me_addr = IW'(32'(r_q) * 32'(side) + 32'(c_q));
		unique case (k_q[1:0])
			2'd0: begin
				nb_ok = c_q != '0;
				nb_addr = me_addr - IW'(1);
			end
			2'd1: begin
				nb_ok = r_q != '0;
				nb_addr = me_addr - IW'(side);
			end
			2'd2: begin
				nb_ok = (c_q + SW'(1)) < side;
				nb_addr = me_addr + IW'(1);
			end
			2'd3: begin
				nb_ok = (r_q + SW'(1)) < side;
				nb_addr = me_addr + IW'(side);
			end
		endcase
	end

	logic last_k, find_more, walk_end, col_next, row_next;
	logic [CW-1:0] sum_ab;
	assign last_k = pass2_q ? (k_q == 3'd4) : (k_q == 3'd2);
	assign find_more = (rd_par_q != root_q) && (steps_q < total);
	assign walk_end = (cur_q == root_q) || (steps_q >= total);
	assign col_next = (c_q + SW'(1)) < side;
	assign row_next = (r_q + SW'(1)) < side;
	assign sum_ab = sa_q + rd_size_q;

	logic seen;
	always_comb begin
		seen = 1'b0;
		for (int i = 0; i < 4; i++)
			if (3'(i) < cnt_q && roots_q[i] == root_q) seen = 1'b1;
	end

	// memory control
	logic we_cell, we_par, we_size;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] par_wa, size_wa;
	logic [IW-1:0] par_wd;
	logic [CW-1:0] size_wd;

	always_ff @(posedge clk) begin
		if (we_cell) cell_mem[loaded_q[IW-1:0]] <= cell_value;
		if (we_par) parent_mem[par_wa] <= par_wd;
		if (we_size) size_mem[size_wa] <= size_wd;
		rd_cell_q <= cell_mem[rd_addr];
		rd_par_q <= parent_mem[rd_addr];
		rd_size_q <= size_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= lio_pkg::ST_LOAD;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		we_cell = 1'b0;
		we_par = 1'b0;
		we_size = 1'b0;
		par_wa = pos_q;
		par_wd = pos_q;
		size_wa = pos_q;
		size_wd = CW'(1);
		rd_addr = me_addr;
		unique case (state_q)
			lio_pkg::ST_LOAD: begin
				we_cell = xfer_in;
				if (xfer_in && last_cell) state_d = lio_pkg::ST_INIT;
			end
			lio_pkg::ST_INIT: begin
				we_par = 1'b1;
				we_size = 1'b1;
				if (init_end) state_d = lio_pkg::ST_CELL_RD;
			end
			lio_pkg::ST_CELL_RD: state_d = lio_pkg::ST_CELL_CHK;
			// The first pass visits land cells, the second one water cells.
			lio_pkg::ST_CELL_CHK:
				state_d = (rd_cell_q ^ pass2_q) ? lio_pkg::ST_NB_SEL : lio_pkg::ST_ADVANCE;
			lio_pkg::ST_NB_SEL: begin
				rd_addr = nb_addr;
				if (last_k) state_d = pass2_q ? lio_pkg::ST_SUM_RD : lio_pkg::ST_ADVANCE;
				else if (nb_ok) state_d = lio_pkg::ST_NB_CHK;
			end
			lio_pkg::ST_NB_CHK:
				state_d = rd_cell_q ? lio_pkg::ST_FIND_RD : lio_pkg::ST_NB_SEL;
			lio_pkg::ST_FIND_RD: begin
				rd_addr = root_q;
				state_d = lio_pkg::ST_FIND_CHK;
			end
			lio_pkg::ST_FIND_CHK:
				state_d = find_more ? lio_pkg::ST_FIND_RD : lio_pkg::ST_CMP_RD;
			lio_pkg::ST_CMP_RD: begin
				rd_addr = cur_q;
				if (!walk_end) state_d = lio_pkg::ST_CMP_WR;
				else if (pass2_q) state_d = lio_pkg::ST_NB_SEL;
				else if (!fsel_q) state_d = lio_pkg::ST_FIND_RD;
				else if (root_q == pa_q) state_d = lio_pkg::ST_NB_SEL;
				else state_d = lio_pkg::ST_UNI_RA;
			end
			lio_pkg::ST_CMP_WR: begin
				we_par = 1'b1;
				par_wa = cur_q;
				par_wd = root_q;
				state_d = lio_pkg::ST_CMP_RD;
			end
			lio_pkg::ST_UNI_RA: begin
				rd_addr = pa_q;
				state_d = lio_pkg::ST_UNI_RB;
			end
			lio_pkg::ST_UNI_RB: begin
				rd_addr = pb_q;
				state_d = lio_pkg::ST_UNI_WR;
			end
			lio_pkg::ST_UNI_WR: begin
				we_par = 1'b1;
				we_size = 1'b1;
				size_wd = sum_ab;
				if (sa_q >= rd_size_q) begin
					par_wa = pb_q;
					par_wd = pa_q;
					size_wa = pa_q;
				end else begin
					par_wa = pa_q;
					par_wd = pb_q;
					size_wa = pb_q;
				end
				state_d = lio_pkg::ST_NB_SEL;
			end
			lio_pkg::ST_SUM_RD: begin
				rd_addr = roots_q[j_q[1:0]];
				state_d = (j_q < cnt_q) ? lio_pkg::ST_SUM_ADD : lio_pkg::ST_ADVANCE;
			end
			lio_pkg::ST_SUM_ADD: state_d = lio_pkg::ST_SUM_RD;
			lio_pkg::ST_ADVANCE: begin
				if (!col_next && !row_next && pass2_q) state_d = lio_pkg::ST_DONE;
				else state_d = lio_pkg::ST_CELL_RD;
			end
			lio_pkg::ST_DONE: if (res_load) state_d = lio_pkg::ST_LOAD;
			default: state_d = lio_pkg::ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_reg_q <= GW'(lio_pkg::SIDE_RESET);
			loaded_q <= '0;
			pos_q <= '0;
			r_q <= '0;
			c_q <= '0;
			k_q <= '0;
			pass2_q <= 1'b0;
			fsel_q <= 1'b0;
			x_q <= '0;
			root_q <= '0;
			cur_q <= '0;
			pa_q <= '0;
			pb_q <= '0;
			steps_q <= '0;
			for (int i = 0; i < 4; i++) roots_q[i] <= '0;
			cnt_q <= '0;
			j_q <= '0;
			sa_q <= '0;
			area_q <= CW'(1);
			best_q <= CW'(1);
			res_q <= AW'(1);
			outv_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				side_reg_q <= cfg_wdata;
				loaded_q <= '0;
			end else if (xfer_in) begin
				loaded_q <= last_cell ? '0 : loaded_q + CW'(1);
			end
			if (res_load) begin
				res_q <= (32'(best_q) > lio_pkg::AREA_MAX) ? AW'(lio_pkg::AREA_MAX)
					: AW'(best_q);
				outv_q <= 1'b1;
			end else if (outv_q && out_ready) begin
				outv_q <= 1'b0;
			end
			unique case (state_q)
				lio_pkg::ST_LOAD: pos_q <= '0;
				lio_pkg::ST_INIT: begin
					pos_q <= pos_q + IW'(1);
					if (init_end) begin
						r_q <= '0;
						c_q <= '0;
						pass2_q <= 1'b0;
						best_q <= CW'(1);
					end
				end
				lio_pkg::ST_CELL_RD: begin
					k_q <= '0;
					cnt_q <= '0;
					j_q <= '0;
					area_q <= CW'(1);
				end
				lio_pkg::ST_NB_SEL: if (!last_k && !nb_ok) k_q <= k_q + 3'd1;
				lio_pkg::ST_NB_CHK: begin
					if (rd_cell_q) begin
						steps_q <= '0;
						fsel_q <= 1'b0;
						if (pass2_q) begin
							root_q <= nb_addr;
							x_q <= nb_addr;
						end else begin
							root_q <= me_addr;
							x_q <= me_addr;
						end
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				lio_pkg::ST_FIND_CHK: begin
					if (find_more) begin
						root_q <= rd_par_q;
						steps_q <= steps_q + CW'(1);
					end else begin
						cur_q <= x_q;
						steps_q <= '0;
					end
				end
				lio_pkg::ST_CMP_RD: begin
					if (walk_end) begin
						if (pass2_q) begin
							if (!seen) begin
								roots_q[cnt_q[1:0]] <= root_q;
								cnt_q <= cnt_q + 3'd1;
							end
							k_q <= k_q + 3'd1;
						end else if (!fsel_q) begin
							// Root of this cell found; walk from the neighbor next.
							pa_q <= root_q;
							fsel_q <= 1'b1;
							root_q <= nb_addr;
							x_q <= nb_addr;
							steps_q <= '0;
						end else begin
							pb_q <= root_q;
							if (root_q == pa_q) k_q <= k_q + 3'd1;
						end
					end
				end
				lio_pkg::ST_CMP_WR: begin
					cur_q <= rd_par_q;
					steps_q <= steps_q + CW'(1);
				end
				lio_pkg::ST_UNI_RB: sa_q <= rd_size_q;
				lio_pkg::ST_UNI_WR: begin
					if (sum_ab > best_q) best_q <= sum_ab;
					k_q <= k_q + 3'd1;
				end
				lio_pkg::ST_SUM_RD: if (j_q >= cnt_q && area_q > best_q) best_q <= area_q;
				lio_pkg::ST_SUM_ADD: begin
					area_q <= area_q + rd_size_q;
					j_q <= j_q + 3'd1;
				end
				lio_pkg::ST_ADVANCE: begin
					if (col_next) begin
						c_q <= c_q + SW'(1);
					end else begin
						c_q <= '0;
						if (row_next) begin
							r_q <= r_q + SW'(1);
						end else begin
							r_q <= '0;
							pass2_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
